FILE: sv/fcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg
// shared types and constants of the frustum cull classifier
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int NUM_PLANES_DEF = 6;
  localparam int COORD_W        = 16;
  localparam int EXTENT_W       = 15;
  localparam int PLANE_W        = 64;
  localparam int FRAC_BITS      = 14;
  localparam int PROD_W         = 2 * COORD_W;
  localparam int ABS_SUM_W      = COORD_W + 2;
  localparam int THR_W          = EXTENT_W + ABS_SUM_W;
  localparam int DIST_W         = PROD_W + 3;
  localparam int CMP_W          = DIST_W + 1;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_CUBE   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    V_OUTSIDE = 2'd0,
    V_PARTIAL = 2'd1,
    V_INSIDE  = 2'd2,
    V_UNUSED  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

FILE: sv/frustum_cull_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_classifier_core
// point, sphere and cube classification against six frustum planes
// ----------------------------------------------------------------------------
// One object test is taken every clock cycle unless the pipeline stalls, and
// each gives one verdict, passing a multiply stage, a distance and threshold
// stage, a compare stage per plane and the verdict output register, all six
// planes worked in parallel lanes. Each stage holds only while the stage after
// it is full and stalled, so bubbles are squeezed out and the input keeps
// taking items while a verdict waits, until all stages fill. The user writes
// planes over the cfg port only while no test is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module frustum_cull_classifier_core #(
  parameter int NUM_PLANES = fcc_pkg::NUM_PLANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,  // pos_x, pos_y, pos_z, extent, zero pad
  input  logic [1:0]                    in_tuser,  // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata, // verdict, zero pad
  input  logic                          cfg_we,
  input  logic [$clog2(NUM_PLANES)-1:0] cfg_addr,
  input  logic [fcc_pkg::PLANE_W-1:0]   cfg_wdata
);

  logic [fcc_pkg::PLANE_W-1:0] planes_r [NUM_PLANES];

  logic signed [fcc_pkg::COORD_W-1:0] pos_x, pos_y, pos_z;
  logic [fcc_pkg::EXTENT_W-1:0]       extent;

  logic         v1_r, v2_r, v3_r;
  fcc_pkg::op_t op_s1_r, op_s2_r, op_s3_r;
  fcc_pkg::stage_en_t en;
  logic         load_ready;

  logic [NUM_PLANES-1:0] out_flags, in_flags;
  fcc_pkg::verdict_t     verdict;

  assign pos_x  = in_tdata[15:0];
  assign pos_y  = in_tdata[31:16];
  assign pos_z  = in_tdata[47:32];
  assign extent = in_tdata[62:48];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes_r[i] <= '0;
      end
    end else if (cfg_we && (32'(cfg_addr) < NUM_PLANES)) begin
      planes_r[cfg_addr] <= cfg_wdata;
    end
  end

  assign en.s3     = !v3_r || load_ready;
  assign en.s2     = !v2_r || en.s3;
  assign en.s1     = !v1_r || en.s2;
  assign in_tready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_tvalid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) op_s1_r <= fcc_pkg::op_t'(in_tuser);
    if (en.s2) op_s2_r <= op_s1_r;
    if (en.s3) op_s3_r <= op_s2_r;
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fcc_plane_lane u_lane (
      .clk      (clk),
      .en       (en),
      .plane    (planes_r[p]),
      .pos_x    (pos_x),
      .pos_y    (pos_y),
      .pos_z    (pos_z),
      .extent   (extent),
      .op_s1    (op_s1_r),
      .out_flag (out_flags[p]),
      .in_flag  (in_flags[p])
    );
  end

  fcc_verdict #(
    .NUM_PLANES (NUM_PLANES)
  ) u_verdict (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_s3   (v3_r),
    .op_s3      (op_s3_r),
    .out_flags  (out_flags),
    .in_flags   (in_flags),
    .load_ready (load_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .verdict    (verdict)
  );

  assign out_tdata = {6'b0, verdict};

endmodule

FILE: sv/fcc_plane_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_plane_lane
// per-plane distance and threshold pipeline, three register stages
// ----------------------------------------------------------------------------
module fcc_plane_lane (
  input  logic                                clk,
  input  fcc_pkg::stage_en_t                  en,
  input  logic [fcc_pkg::PLANE_W-1:0]         plane,
  input  logic signed [fcc_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [fcc_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [fcc_pkg::COORD_W-1:0]  pos_z,
  input  logic [fcc_pkg::EXTENT_W-1:0]        extent,
  input  fcc_pkg::op_t                        op_s1,
  output logic                                out_flag,
  output logic                                in_flag
);

  localparam int CW = fcc_pkg::COORD_W;

  logic signed [CW-1:0] a, b, c, d;
  logic [fcc_pkg::ABS_SUM_W-1:0] abs_a, abs_b, abs_c, abs_sum;

  logic signed [fcc_pkg::PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [fcc_pkg::PROD_W-1:0] px_r, py_r, pz_r;
  logic [fcc_pkg::THR_W-1:0]         m_nxt, m_r;
  logic [fcc_pkg::EXTENT_W-1:0]      e_s1_r;

  logic signed [fcc_pkg::DIST_W-1:0] dist_nxt, dist_r;
  logic [fcc_pkg::THR_W-1:0]         thr_nxt, thr_r;

  logic signed [fcc_pkg::CMP_W-1:0]  hi_sum, lo_sum;
  logic                              out_flag_r, in_flag_r;

  assign a = plane[15:0];
  assign b = plane[31:16];
  assign c = plane[47:32];
  assign d = plane[63:48];

  assign abs_a = a[CW-1] ? (fcc_pkg::ABS_SUM_W'(0) - fcc_pkg::ABS_SUM_W'(a))
                         : fcc_pkg::ABS_SUM_W'(unsigned'(a));
  assign abs_b = b[CW-1] ? (fcc_pkg::ABS_SUM_W'(0) - fcc_pkg::ABS_SUM_W'(b))
                         : fcc_pkg::ABS_SUM_W'(unsigned'(b));
  assign abs_c = c[CW-1] ? (fcc_pkg::ABS_SUM_W'(0) - fcc_pkg::ABS_SUM_W'(c))
                         : fcc_pkg::ABS_SUM_W'(unsigned'(c));
  assign abs_sum = abs_a + abs_b + abs_c;

  // stage 1: products
  assign px_nxt = a * pos_x;
  assign py_nxt = b * pos_y;
  assign pz_nxt = c * pos_z;
  assign m_nxt  = fcc_pkg::THR_W'(extent) * fcc_pkg::THR_W'(abs_sum);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      m_r    <= m_nxt;
      e_s1_r <= extent;
    end
  end

  // stage 2: centre distance and threshold
  always_comb begin
    dist_nxt = fcc_pkg::DIST_W'(px_r) + fcc_pkg::DIST_W'(py_r) + fcc_pkg::DIST_W'(pz_r)
             + (fcc_pkg::DIST_W'(d) <<< fcc_pkg::FRAC_BITS);
    unique case (op_s1)
      fcc_pkg::OP_SPHERE: thr_nxt = fcc_pkg::THR_W'(e_s1_r) << fcc_pkg::FRAC_BITS;
      fcc_pkg::OP_CUBE:   thr_nxt = m_r;
      default:            thr_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      dist_r <= dist_nxt;
      thr_r  <= thr_nxt;
    end
  end

  // stage 3: plane compares
  assign hi_sum = fcc_pkg::CMP_W'(dist_r) + signed'(fcc_pkg::CMP_W'(thr_r));
  assign lo_sum = fcc_pkg::CMP_W'(dist_r) - signed'(fcc_pkg::CMP_W'(thr_r));

  always_ff @(posedge clk) begin
    if (en.s3) begin
      out_flag_r <= (hi_sum <= 0);
      in_flag_r  <= (lo_sum > 0);
    end
  end

  assign out_flag = out_flag_r;
  assign in_flag  = in_flag_r;

endmodule

FILE: sv/fcc_verdict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_verdict
// combines plane flags into a verdict and holds the output register
// ----------------------------------------------------------------------------
module fcc_verdict #(
  parameter int NUM_PLANES = fcc_pkg::NUM_PLANES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_s3,
  input  fcc_pkg::op_t            op_s3,
  input  logic [NUM_PLANES-1:0]   out_flags,
  input  logic [NUM_PLANES-1:0]   in_flags,
  output logic                    load_ready,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output fcc_pkg::verdict_t       verdict
);

  logic              out_valid_r;
  fcc_pkg::verdict_t verdict_r, verdict_nxt;

  assign load_ready = !out_valid_r || out_tready;

  always_comb begin
    priority if (op_s3 == fcc_pkg::OP_RSVD || (|out_flags)) begin
      verdict_nxt = fcc_pkg::V_OUTSIDE;
    end else if (&in_flags) begin
      verdict_nxt = fcc_pkg::V_INSIDE;
    end else begin
      verdict_nxt = fcc_pkg::V_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_ready) begin
      out_valid_r <= valid_s3;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign verdict    = verdict_r;

endmodule

FILE: sv/fcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_checker
// port-level checks on the frustum cull classifier
// ----------------------------------------------------------------------------
module fcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // stalled result transfer holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled verdict changed");

  // verdict code is one of the three meaningful ones, padding is zero
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3) && (out_tdata[7:2] == 6'd0))
    else $error("bad verdict code");

  // an empty output register lets the whole pipeline move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("verdict valid after reset");

endmodule

bind frustum_cull_classifier_core fcc_checker u_fcc_checker (.*);
